[src/obrl_pkg.sv]
// Shared types and constants of the overwrite byte ring log.
`timescale 1ns / 1ps
`default_nettype none

package obrl_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 7;

	localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] SIZE_RESET = 7'd64;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [6:0] read_count;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       none_stored;
	} rsp_t;

endpackage

`default_nettype wire

[src/obrl_ram.sv]
// Byte store of the ring: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module obrl_ram (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire obrl_pkg::addr_t wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire obrl_pkg::addr_t rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [obrl_pkg::DEPTH];

	// write one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read of one byte
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/overwrite_byte_ring_log_top.sv]
// Top level of the overwrite byte ring log: control, head/count state, output queue.
// Append, clear and no-op items can come every cycle while req_ready is high. A read of
// n stored bytes issues one store read per cycle while the output queue has room and
// stays busy until all n are issued; each byte passes the store's read register, then
// the output queue. The single store read port sets the one-byte-per-cycle rate.
// Reset (arst_n low) empties the ring and the output queue and sets ring_size to 64.
`timescale 1ns / 1ps
`default_nettype none

module overwrite_byte_ring_log_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire obrl_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output obrl_pkg::rsp_t       rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [6:0]      cfg_data
);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t            state_q;
	obrl_pkg::count_t  ring_size_q;
	obrl_pkg::addr_t   head_q;
	obrl_pkg::count_t  held_q;
	obrl_pkg::addr_t   pos_q;
	obrl_pkg::count_t  remain_q;

	logic              valid_s1;
	logic              last_s1;
	logic              empty_s1;

	obrl_pkg::rsp_t    fifo0_q;
	obrl_pkg::rsp_t    fifo1_q;
	logic [1:0]        occ_q;

	obrl_pkg::count_t  size;
	obrl_pkg::count_t  head_eff;
	obrl_pkg::count_t  held_eff;
	obrl_pkg::count_t  head_inc;
	obrl_pkg::count_t  cnt_sat;
	obrl_pkg::count_t  n_rd;
	obrl_pkg::count_t  start_sum;
	obrl_pkg::count_t  start_pos;
	obrl_pkg::count_t  pos_inc;
	logic              req_xfer;
	logic              pop;
	logic              push;
	logic              issue_ok;
	logic              rd_issue;
	logic              empty_issue;
	logic              wr_en;
	logic [7:0]        rd_data;
	obrl_pkg::rsp_t    push_data;
	obrl_pkg::action_t act;

	assign act = obrl_pkg::action_t'(req.action);

	// clamp size, head and count to the configured ring
	always_comb begin
		if (ring_size_q == '0) begin
			size = obrl_pkg::count_t'(1);
		end else if (ring_size_q > obrl_pkg::SIZE_MAX) begin
			size = obrl_pkg::SIZE_MAX;
		end else begin
			size = ring_size_q;
		end
		head_eff = ({1'b0, head_q} < size) ? {1'b0, head_q} : '0;
		held_eff = (held_q > size) ? size : held_q;
		head_inc = head_eff + obrl_pkg::count_t'(1);
		cnt_sat  = (req.read_count > obrl_pkg::SIZE_MAX) ? obrl_pkg::SIZE_MAX
		                                                  : req.read_count;
		n_rd      = (held_eff < cnt_sat) ? held_eff : cnt_sat;
		start_sum = head_eff + size - n_rd;
		start_pos = (start_sum >= size) ? start_sum - size : start_sum;
		pos_inc   = {1'b0, pos_q} + obrl_pkg::count_t'(1);
	end

	// allow a new store read only if its byte will find queue space
	assign pop      = rsp_valid && rsp_ready;
	assign issue_ok = ({1'b0, occ_q} + {2'b00, valid_s1}) <= ({2'b00, pop} + 3'd1);
	assign req_ready = (state_q == ST_IDLE) && issue_ok;
	assign req_xfer  = req_valid && req_ready;
	assign cfg_ready = 1'b1;

	assign wr_en       = req_xfer && (act == obrl_pkg::ACT_APPEND);
	assign rd_issue    = (state_q == ST_READ) && issue_ok;
	assign empty_issue = req_xfer && (act == obrl_pkg::ACT_READ) && (n_rd == '0);

	obrl_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (head_eff[obrl_pkg::ADDR_W-1:0]),
		.wr_data (req.data_byte),
		.rd_en   (rd_issue),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	// hold the ring size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= obrl_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ring_size_q <= cfg_data;
		end
	end

	// sequence items: update head and count, walk read runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			held_q   <= '0;
			pos_q    <= '0;
			remain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						case (act)
							obrl_pkg::ACT_APPEND: begin
								head_q <= (head_inc >= size) ? '0
								          : head_inc[obrl_pkg::ADDR_W-1:0];
								held_q <= (held_eff < size) ? held_eff + obrl_pkg::count_t'(1)
								          : held_eff;
							end
							obrl_pkg::ACT_CLEAR: begin
								head_q <= '0;
								held_q <= '0;
							end
							obrl_pkg::ACT_READ: begin
								if (n_rd != '0) begin
									pos_q    <= start_pos[obrl_pkg::ADDR_W-1:0];
									remain_q <= n_rd;
									state_q  <= ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					if (rd_issue) begin
						pos_q    <= (pos_inc >= size) ? '0 : pos_inc[obrl_pkg::ADDR_W-1:0];
						remain_q <= remain_q - obrl_pkg::count_t'(1);
						if (remain_q == obrl_pkg::count_t'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// track the store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			empty_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_issue || empty_issue;
			last_s1  <= empty_issue || (remain_q == obrl_pkg::count_t'(1));
			empty_s1 <= empty_issue;
		end
	end

	assign push                  = valid_s1;
	assign push_data.out_byte    = empty_s1 ? 8'd0 : rd_data;
	assign push_data.is_last     = last_s1;
	assign push_data.none_stored = empty_s1;

	// two-entry output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   occ_q <= occ_q + 2'd1;
				2'b01:   occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (occ_q == 2'd0) begin
					fifo0_q <= push_data;
				end else begin
					fifo1_q <= push_data;
				end
			end
			2'b01: begin
				fifo0_q <= fifo1_q;
			end
			2'b11: begin
				if (occ_q == 2'd1) begin
					fifo0_q <= push_data;
				end else begin
					fifo0_q <= fifo1_q;
					fifo1_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = (occ_q != 2'd0);
	assign rsp       = fifo0_q;

endmodule

`default_nettype wire

[src/obrl_checker.sv]
// Port-level checks of the overwrite byte ring log and their binding.
`timescale 1ns / 1ps
`default_nettype none

module obrl_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire obrl_pkg::rsp_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	// an empty read ends its run and carries a zero byte
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.none_stored |-> rsp.is_last && (rsp.out_byte == 8'd0))
		else $error("empty result not marked last or byte not zero");

	// start with no result after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !rsp_valid)
		else $error("result shown right after reset");

	// an empty result taken with no request offered and req_ready low is not followed at once by another empty result
	a_req_ready_after_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.none_stored && !req_valid |=> !rsp_valid || !rsp.none_stored
		|| $past(req_ready))
		else $error("stray empty result");

endmodule

bind overwrite_byte_ring_log_top obrl_checker u_obrl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
